[hdl/tfsc_pkg.sv]
// ----------------------------------------------------------------------------
// tfsc_pkg
// Shared types, constants and helpers for the test frame sequence checker.
// ----------------------------------------------------------------------------
package tfsc_pkg;

    localparam int MAX_FRAME   = 4096;
    localparam int POS_W       = $clog2(MAX_FRAME + 1);
    localparam int HEADER_LEN  = 20;
    localparam int SEQ_HI_POS  = 2;
    localparam int SEQ_LO_POS  = 3;
    localparam int ERR_W       = 12;
    localparam int ERR_MAX     = (1 << ERR_W) - 1;
    localparam int SEQ_W       = 16;
    localparam int CNT_W       = 32;
    localparam int IVL_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        REQ_BYTE = 1'b0,
        REQ_TICK = 1'b1
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_CHECK_PAYLOAD = 1'b0,
        CFG_STATS_IVL     = 1'b1
    } cfg_idx_t;

    // One finished frame, handed from the front end to the back end.
    typedef struct packed
    {
        logic [POS_W-1:0] len;
        logic             runt;
        logic [SEQ_W-1:0] seq;
        logic [ERR_W-1:0] errs;
        logic [CNT_W-1:0] secs;
    } frame_rec_t;

    typedef struct packed
    {
        logic [SEQ_W-1:0] seq_number;
        logic [SEQ_W-1:0] seq_gap;
        logic [ERR_W-1:0] payload_errors;
        logic             frame_error;
        logic             runt_frame;
        logic             stats_valid;
        logic [CNT_W-1:0] stats_packets;
        logic [CNT_W-1:0] stats_bytes;
        logic [CNT_W-1:0] stats_missed;
        logic [CNT_W-1:0] stats_error_bytes;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

[hdl/tfsc_front.sv]
// ----------------------------------------------------------------------------
// tfsc_front
// Byte parser: tracks position, sequence number and payload pattern errors,
// keeps the seconds count and emits one record per finished frame.
// ----------------------------------------------------------------------------
module tfsc_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    req_type,
    input  logic [7:0]              frame_byte,
    input  logic                    end_of_frame,
    input  logic                    check_payload,
    output logic                    rec_push,
    output tfsc_pkg::frame_rec_t    rec
);

    logic [tfsc_pkg::POS_W-1:0] pos_reg, pos_next, pos_d;
    logic [7:0]                 seq_hi_reg, seq_hi_next, seq_hi_d;
    logic [tfsc_pkg::SEQ_W-1:0] seq_reg, seq_next, seq_d;
    logic [tfsc_pkg::ERR_W-1:0] err_reg, err_next, err_d;
    logic [tfsc_pkg::CNT_W-1:0] secs_reg, secs_next;
    logic [tfsc_pkg::POS_W-1:0] pay_idx;

    assign pay_idx = pos_reg - tfsc_pkg::POS_W'(tfsc_pkg::HEADER_LEN);

    always_comb
    begin
        pos_d    = pos_reg;
        seq_hi_d = seq_hi_reg;
        seq_d    = seq_reg;
        err_d    = err_reg;

        if (pos_reg < tfsc_pkg::POS_W'(tfsc_pkg::MAX_FRAME))
        begin
            if (pos_reg == tfsc_pkg::POS_W'(tfsc_pkg::SEQ_HI_POS))
            begin
                seq_hi_d = frame_byte;
            end
            else if (pos_reg == tfsc_pkg::POS_W'(tfsc_pkg::SEQ_LO_POS))
            begin
                seq_d = {seq_hi_reg, frame_byte};
            end
            else if (pos_reg >= tfsc_pkg::POS_W'(tfsc_pkg::HEADER_LEN) && check_payload)
            begin
                if (frame_byte != pay_idx[7:0] &&
                    err_reg != tfsc_pkg::ERR_W'(tfsc_pkg::ERR_MAX))
                begin
                    err_d = err_reg + 1'b1;
                end
            end
            pos_d = pos_reg + 1'b1;
        end

        pos_next    = pos_reg;
        seq_hi_next = seq_hi_reg;
        seq_next    = seq_reg;
        err_next    = err_reg;
        secs_next   = secs_reg;
        rec_push    = 1'b0;

        rec.len  = pos_d;
        rec.runt = pos_d < tfsc_pkg::POS_W'(tfsc_pkg::HEADER_LEN);
        rec.seq  = seq_d;
        rec.errs = err_d;
        rec.secs = secs_reg;

        if (accept)
        begin
            if (req_type == tfsc_pkg::REQ_TICK)
            begin
                secs_next = secs_reg + 1'b1;
            end
            else if (end_of_frame)
            begin
                rec_push    = 1'b1;
                pos_next    = '0;
                seq_hi_next = '0;
                seq_next    = '0;
                err_next    = '0;
            end
            else
            begin
                pos_next    = pos_d;
                seq_hi_next = seq_hi_d;
                seq_next    = seq_d;
                err_next    = err_d;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            seq_hi_reg <= '0;
            seq_reg    <= '0;
            err_reg    <= '0;
            secs_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            seq_hi_reg <= seq_hi_next;
            seq_reg    <= seq_next;
            err_reg    <= err_next;
            secs_reg   <= secs_next;
        end
    end

endmodule

[hdl/tfsc_queue.sv]
// ----------------------------------------------------------------------------
// tfsc_queue
// Small FIFO of frame records between the parser and the statistics unit.
// ----------------------------------------------------------------------------
module tfsc_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  tfsc_pkg::frame_rec_t    wr_data,
    input  logic                    rd_en,
    output tfsc_pkg::frame_rec_t    rd_data,
    output logic                    not_empty,
    output logic                    full
);

    tfsc_pkg::frame_rec_t        entry_reg [tfsc_pkg::QUEUE_DEPTH];
    logic [tfsc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tfsc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tfsc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        do_wr, do_rd;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == tfsc_pkg::QCNT_W'(tfsc_pkg::QUEUE_DEPTH);
    assign rd_data   = entry_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == tfsc_pkg::QPTR_W'(tfsc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == tfsc_pkg::QPTR_W'(tfsc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tfsc_pkg::QCNT_W'(tfsc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a write");

endmodule

[hdl/tfsc_back.sv]
// ----------------------------------------------------------------------------
// tfsc_back
// Sequence gap tracking, interval statistics and the result register.
// ----------------------------------------------------------------------------
module tfsc_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rec_valid,
    input  tfsc_pkg::frame_rec_t         rec,
    output logic                         rec_pop,
    input  logic [tfsc_pkg::IVL_W-1:0]   stats_interval,
    input  logic                         pop,
    output logic                         res_valid,
    output tfsc_pkg::result_t            res
);

    logic [tfsc_pkg::SEQ_W-1:0] prev_seq_reg, prev_seq_next;
    logic                       have_prev_reg, have_prev_next;
    logic [tfsc_pkg::CNT_W-1:0] ivl_start_reg, ivl_start_next;
    logic [tfsc_pkg::CNT_W-1:0] pkt_reg, pkt_next;
    logic [tfsc_pkg::CNT_W-1:0] bytes_reg, bytes_next;
    logic [tfsc_pkg::CNT_W-1:0] missed_reg, missed_next;
    logic [tfsc_pkg::CNT_W-1:0] errb_reg, errb_next;
    logic                       out_valid_reg, out_valid_next;
    tfsc_pkg::result_t          res_reg, res_next;

    logic                       take;
    logic [tfsc_pkg::SEQ_W-1:0] gap;
    logic [tfsc_pkg::CNT_W-1:0] pkt_sum, bytes_sum, elapsed, missed_base, errb_base;
    logic                       report;

    // output register frees up in the same cycle it is popped
    assign take      = !out_valid_reg || pop;
    assign rec_pop   = take && rec_valid;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        gap = (have_prev_reg && !rec.runt) ? rec.seq - prev_seq_reg : '0;
        pkt_sum   = tfsc_pkg::sat_add(pkt_reg, tfsc_pkg::CNT_W'(1));
        bytes_sum = tfsc_pkg::sat_add(bytes_reg, tfsc_pkg::CNT_W'(rec.len));
        elapsed   = rec.secs - ivl_start_reg;
        report    = elapsed >= tfsc_pkg::CNT_W'(stats_interval);
        missed_base = report ? '0 : missed_reg;
        errb_base   = report ? '0 : errb_reg;

        res_next = '0;
        if (!rec.runt)
        begin
            res_next.seq_number     = rec.seq;
            res_next.seq_gap        = gap;
            res_next.payload_errors = rec.errs;
            res_next.frame_error    = (gap > tfsc_pkg::SEQ_W'(1)) || (rec.errs != '0);
        end
        res_next.runt_frame = rec.runt;
        if (report)
        begin
            res_next.stats_valid       = 1'b1;
            res_next.stats_packets     = pkt_sum;
            res_next.stats_bytes       = bytes_sum;
            res_next.stats_missed      = missed_reg;
            res_next.stats_error_bytes = errb_reg;
        end

        prev_seq_next  = prev_seq_reg;
        have_prev_next = have_prev_reg;
        ivl_start_next = ivl_start_reg;
        pkt_next       = pkt_reg;
        bytes_next     = bytes_reg;
        missed_next    = missed_reg;
        errb_next      = errb_reg;
        out_valid_next = out_valid_reg;

        if (take)
        begin
            out_valid_next = rec_valid;
        end

        if (rec_pop)
        begin
            pkt_next    = report ? '0 : pkt_sum;
            bytes_next  = report ? '0 : bytes_sum;
            missed_next = missed_base;
            errb_next   = errb_base;
            if (report)
            begin
                ivl_start_next = rec.secs;
            end
            if (!rec.runt)
            begin
                if (gap > tfsc_pkg::SEQ_W'(1))
                begin
                    missed_next = tfsc_pkg::sat_add(missed_base,
                                      tfsc_pkg::CNT_W'(gap - 1'b1));
                end
                errb_next      = tfsc_pkg::sat_add(errb_base, tfsc_pkg::CNT_W'(rec.errs));
                prev_seq_next  = rec.seq;
                have_prev_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seq_reg  <= '1;
            have_prev_reg <= 1'b0;
            ivl_start_reg <= '0;
            pkt_reg       <= '0;
            bytes_reg     <= '0;
            missed_reg    <= '0;
            errb_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_seq_reg  <= prev_seq_next;
            have_prev_reg <= have_prev_next;
            ivl_start_reg <= ivl_start_next;
            pkt_reg       <= pkt_next;
            bytes_reg     <= bytes_next;
            missed_reg    <= missed_next;
            errb_reg      <= errb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            res_reg <= res_next;
        end
    end

    a_runt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.runt_frame) |->
        (res_reg.seq_number == '0 && res_reg.seq_gap == '0 && !res_reg.frame_error))
        else $error("runt result carries sequence fields");

    a_no_stats: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.stats_valid) |->
        (res_reg.stats_packets == '0 && res_reg.stats_bytes == '0))
        else $error("stats fields set without a report");

    a_report_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.stats_valid) |-> res_reg.stats_packets != '0)
        else $error("report without the current frame counted");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_pop && report) |=> pkt_reg == '0 && bytes_reg == '0)
        else $error("interval counters not cleared after report");

endmodule

[hdl/test_frame_sequence_checker_top.sv]
// ----------------------------------------------------------------------------
// test_frame_sequence_checker_top
// Test frame sequence and payload pattern checker with interval statistics.
// ----------------------------------------------------------------------------
// Takes one input item (frame byte or one-second tick) per clock. The parser
// tracks the header sequence number and payload pattern errors; at each end
// of frame it queues a record into a four-entry queue, and the statistics
// unit turns one record per clock, while the output register is free or
// popped, into a result held in that register. A result passes through its
// queue entry and the output register, in that order. The input side stalls
// (full) only when the four-entry queue is full, which takes five finished
// frames waiting on pop (one in the output register, four queued); while full,
// every input transfer waits, ticks and mid-frame bytes included.
// Configuration writes are registered before they take effect.
module test_frame_sequence_checker_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              req_type,
    input  logic [7:0]                        frame_byte,
    input  logic                              end_of_frame,
    output logic                              empty,
    input  logic                              pop,
    output logic [tfsc_pkg::SEQ_W-1:0]        seq_number,
    output logic [tfsc_pkg::SEQ_W-1:0]        seq_gap,
    output logic [tfsc_pkg::ERR_W-1:0]        payload_errors,
    output logic                              frame_error,
    output logic                              runt_frame,
    output logic                              stats_valid,
    output logic [tfsc_pkg::CNT_W-1:0]        stats_packets,
    output logic [tfsc_pkg::CNT_W-1:0]        stats_bytes,
    output logic [tfsc_pkg::CNT_W-1:0]        stats_missed,
    output logic [tfsc_pkg::CNT_W-1:0]        stats_error_bytes,
    input  logic                              cfg_we,
    input  logic [tfsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                       check_payload_reg, check_payload_next;
    logic [tfsc_pkg::IVL_W-1:0] stats_ivl_reg, stats_ivl_next;
    logic                       accept;
    logic                       rec_push, rec_pop, rec_valid;
    tfsc_pkg::frame_rec_t       rec_in, rec_out;
    logic                       res_valid;
    tfsc_pkg::result_t          res;

    assign accept = push && !full;

    always_comb
    begin
        check_payload_next = check_payload_reg;
        stats_ivl_next     = stats_ivl_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tfsc_pkg::CFG_CHECK_PAYLOAD: check_payload_next = cfg_data[0];
                tfsc_pkg::CFG_STATS_IVL:     stats_ivl_next = cfg_data[tfsc_pkg::IVL_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_payload_reg <= 1'b0;
            stats_ivl_reg     <= tfsc_pkg::IVL_W'(1);
        end
        else
        begin
            check_payload_reg <= check_payload_next;
            stats_ivl_reg     <= stats_ivl_next;
        end
    end

    tfsc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (req_type),
        .frame_byte    (frame_byte),
        .end_of_frame  (end_of_frame),
        .check_payload (check_payload_reg),
        .rec_push      (rec_push),
        .rec           (rec_in)
    );

    tfsc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec_in),
        .rd_en     (rec_pop),
        .rd_data   (rec_out),
        .not_empty (rec_valid),
        .full      (full)
    );

    tfsc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rec_valid      (rec_valid),
        .rec            (rec_out),
        .rec_pop        (rec_pop),
        .stats_interval (stats_ivl_reg),
        .pop            (pop),
        .res_valid      (res_valid),
        .res            (res)
    );

    assign empty             = !res_valid;
    assign seq_number        = res.seq_number;
    assign seq_gap           = res.seq_gap;
    assign payload_errors    = res.payload_errors;
    assign frame_error       = res.frame_error;
    assign runt_frame        = res.runt_frame;
    assign stats_valid       = res.stats_valid;
    assign stats_packets     = res.stats_packets;
    assign stats_bytes       = res.stats_bytes;
    assign stats_missed      = res.stats_missed;
    assign stats_error_bytes = res.stats_error_bytes;

endmodule

[tb/tb_test_frame_sequence_checker_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_test_frame_sequence_checker_top
// Self-checking bench for the test frame sequence checker. A queue-fed driver
// pushes frame bytes and second ticks, a local model predicts each frame
// report, and a monitor compares every popped report field by field.
// ----------------------------------------------------------------------------
module tb_test_frame_sequence_checker_top;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 120;
    localparam int SETTLE      = 4;

    typedef struct packed
    {
        tfsc_pkg::req_t kind;
        logic [7:0]     data;
        logic           last;
    } link_item_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             push = 1'b0;
    logic                             full;
    logic                             req_type = tfsc_pkg::REQ_BYTE;
    logic [7:0]                       frame_byte = 8'h00;
    logic                             end_of_frame = 1'b0;
    logic                             empty;
    logic                             pop = 1'b0;
    logic [tfsc_pkg::SEQ_W-1:0]       seq_number;
    logic [tfsc_pkg::SEQ_W-1:0]       seq_gap;
    logic [tfsc_pkg::ERR_W-1:0]       payload_errors;
    logic                             frame_error;
    logic                             runt_frame;
    logic                             stats_valid;
    logic [tfsc_pkg::CNT_W-1:0]       stats_packets;
    logic [tfsc_pkg::CNT_W-1:0]       stats_bytes;
    logic [tfsc_pkg::CNT_W-1:0]       stats_missed;
    logic [tfsc_pkg::CNT_W-1:0]       stats_error_bytes;
    logic                             cfg_we = 1'b0;
    logic [tfsc_pkg::CFG_IDX_W-1:0]   cfg_index = tfsc_pkg::CFG_CHECK_PAYLOAD;
    logic [tfsc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // stimulus and scoreboard storage
    link_item_t          link_items[$];
    tfsc_pkg::result_t   frame_reports_due[$];

    // predicted checker state
    logic [tfsc_pkg::POS_W-1:0]  pos_now = '0;
    logic [7:0]                  seq_hi_hold = '0;
    logic [tfsc_pkg::SEQ_W-1:0]  seq_held = '0;
    logic [tfsc_pkg::ERR_W-1:0]  errs_in_frame = '0;
    logic [tfsc_pkg::SEQ_W-1:0]  prior_seq = '1;
    logic                        prior_valid = 1'b0;
    logic [31:0]                 secs_elapsed = '0;
    logic [31:0]                 ivl_mark = '0;
    logic [31:0]                 pkts_ivl = '0;
    logic [31:0]                 bytes_ivl = '0;
    logic [31:0]                 missed_ivl = '0;
    logic [31:0]                 errbytes_ivl = '0;
    logic                        want_check = 1'b0;
    logic [tfsc_pkg::IVL_W-1:0]  want_interval = 16'd1;

    int fail_count = 0;
    int bytes_in = 0;
    int ticks_in = 0;
    int reports_out = 0;
    int runts_out = 0;
    int flagged_out = 0;
    int ivl_reports = 0;
    int full_stalls = 0;
    int quiet_cycles = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int recv_hold = 0;
    bit sender_gaps_on = 1'b0;
    bit receiver_gaps_on = 1'b0;
    logic [15:0] stim_seq = '0;

    test_frame_sequence_checker_top uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .frame_byte        (frame_byte),
        .end_of_frame      (end_of_frame),
        .empty             (empty),
        .pop               (pop),
        .seq_number        (seq_number),
        .seq_gap           (seq_gap),
        .payload_errors    (payload_errors),
        .frame_error       (frame_error),
        .runt_frame        (runt_frame),
        .stats_valid       (stats_valid),
        .stats_packets     (stats_packets),
        .stats_bytes       (stats_bytes),
        .stats_missed      (stats_missed),
        .stats_error_bytes (stats_error_bytes),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] total;
        total = a + b;
        return (total > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // Advance the frame model by one accepted transfer; queue a report on end of frame.
    function automatic void predict_frame_item(input link_item_t it);
        tfsc_pkg::result_t           rep;
        logic [tfsc_pkg::SEQ_W-1:0]  gap;
        logic [tfsc_pkg::POS_W-1:0]  len;
        logic                        runt;
        if (it.kind == tfsc_pkg::REQ_TICK)
        begin
            secs_elapsed = secs_elapsed + 1;
            return;
        end
        if (pos_now < tfsc_pkg::MAX_FRAME)
        begin
            if (pos_now == tfsc_pkg::SEQ_HI_POS)
                seq_hi_hold = it.data;
            else if (pos_now == tfsc_pkg::SEQ_LO_POS)
                seq_held = {seq_hi_hold, it.data};
            else if (pos_now >= tfsc_pkg::HEADER_LEN && want_check &&
                     it.data != 8'(pos_now - tfsc_pkg::HEADER_LEN) &&
                     errs_in_frame != tfsc_pkg::ERR_MAX)
                errs_in_frame = errs_in_frame + 1;
            pos_now = pos_now + 1;
        end
        if (!it.last)
            return;
        rep = '0;
        gap = '0;
        len = pos_now;
        runt = len < tfsc_pkg::HEADER_LEN;
        if (!runt)
        begin
            if (prior_valid)
                gap = seq_held - prior_seq;
            rep.seq_number = seq_held;
            rep.seq_gap = gap;
            rep.payload_errors = errs_in_frame;
            rep.frame_error = (gap > 1) || (errs_in_frame != 0);
        end
        else
            rep.runt_frame = 1'b1;
        pkts_ivl = clamp_add(pkts_ivl, 32'd1);
        bytes_ivl = clamp_add(bytes_ivl, 32'(len));
        if (secs_elapsed - ivl_mark >= 32'(want_interval))
        begin
            rep.stats_valid = 1'b1;
            rep.stats_packets = pkts_ivl;
            rep.stats_bytes = bytes_ivl;
            rep.stats_missed = missed_ivl;
            rep.stats_error_bytes = errbytes_ivl;
            pkts_ivl = '0;
            bytes_ivl = '0;
            missed_ivl = '0;
            errbytes_ivl = '0;
            ivl_mark = secs_elapsed;
        end
        // runts report but leave the sequence history alone
        if (!runt)
        begin
            if (gap > 1)
                missed_ivl = clamp_add(missed_ivl, 32'(gap) - 32'd1);
            errbytes_ivl = clamp_add(errbytes_ivl, 32'(errs_in_frame));
            prior_seq = seq_held;
            prior_valid = 1'b1;
        end
        pos_now = '0;
        seq_hi_hold = '0;
        seq_held = '0;
        errs_in_frame = '0;
        frame_reports_due.push_back(rep);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // sender side: one transfer per edge at most, with random idle bursts
    always @(posedge clk)
    begin : link_driver
        link_item_t nxt;
        if (rst_n && (!push || !full))
        begin
            if (send_idle != 0)
            begin
                send_idle--;
                push <= 1'b0;
            end
            else if (sender_gaps_on && $urandom_range(0, 11) == 0)
            begin
                send_idle = $urandom_range(0, 15);
                push <= 1'b0;
            end
            else if (link_items.size() != 0)
            begin
                nxt = link_items.pop_front();
                push <= 1'b1;
                req_type <= nxt.kind;
                frame_byte <= nxt.data;
                end_of_frame <= nxt.last;
            end
            else
                push <= 1'b0;
        end
    end

    // receiver side: long hold-off when requested, otherwise random idle bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (recv_hold != 0)
            begin
                recv_hold--;
                pop <= 1'b0;
            end
            else if (recv_idle != 0)
            begin
                recv_idle--;
                pop <= 1'b0;
            end
            else if (receiver_gaps_on && $urandom_range(0, 9) == 0)
            begin
                recv_idle = $urandom_range(0, 15);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // input side monitor: feeds the model, tracks config writes, watchdog
    always @(posedge clk)
    begin : input_monitor
        link_item_t seen;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == tfsc_pkg::CFG_CHECK_PAYLOAD)
                    want_check = cfg_data[0];
                else if (cfg_index == tfsc_pkg::CFG_STATS_IVL)
                    want_interval = cfg_data;
            end
            if (push && full)
                full_stalls++;
            if (push && !full)
            begin
                seen.kind = tfsc_pkg::req_t'(req_type);
                seen.data = frame_byte;
                seen.last = end_of_frame;
                if (seen.kind == tfsc_pkg::REQ_TICK)
                    ticks_in++;
                else
                    bytes_in++;
                predict_frame_item(seen);
            end
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles == STALL_LIMIT)
                begin
                    $display("test_frame_sequence_checker_top verification failed");
                    $finish;
                end
            end
        end
    end

    // output side monitor: every popped report against the oldest prediction
    always @(posedge clk)
    begin : report_monitor
        tfsc_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (frame_reports_due.size() == 0)
            begin
                $error("frame report popped with none predicted (seq_number 0x%0h)",
                       seq_number);
                fail_count++;
            end
            else
            begin
                want = frame_reports_due.pop_front();
                reports_out++;
                if (want.runt_frame)
                    runts_out++;
                if (want.frame_error)
                    flagged_out++;
                if (want.stats_valid)
                    ivl_reports++;
                check_field("seq_number", 32'(want.seq_number), 32'(seq_number));
                check_field("seq_gap", 32'(want.seq_gap), 32'(seq_gap));
                check_field("payload_errors", 32'(want.payload_errors), 32'(payload_errors));
                check_field("frame_error", 32'(want.frame_error), 32'(frame_error));
                check_field("runt_frame", 32'(want.runt_frame), 32'(runt_frame));
                check_field("stats_valid", 32'(want.stats_valid), 32'(stats_valid));
                check_field("stats_packets", want.stats_packets, stats_packets);
                check_field("stats_bytes", want.stats_bytes, stats_bytes);
                check_field("stats_missed", want.stats_missed, stats_missed);
                check_field("stats_error_bytes", want.stats_error_bytes, stats_error_bytes);
            end
        end
    end

    task automatic queue_tick();
        link_item_t it;
        it.kind = tfsc_pkg::REQ_TICK;
        it.data = 8'($urandom);
        it.last = 1'($urandom);
        link_items.push_back(it);
    endtask

    // Queue byte positions first..stop-1 of a frame of length len.
    task automatic queue_frame(input logic [15:0] seq, input int len, input int first,
                               input int stop, input int err_pct, input int tick_pct);
        link_item_t it;
        logic [7:0] pattern;
        for (int p = first; p < stop; p++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                queue_tick();
            pattern = 8'(p - tfsc_pkg::HEADER_LEN);
            it.kind = tfsc_pkg::REQ_BYTE;
            it.last = (p == len - 1);
            if (p == tfsc_pkg::SEQ_HI_POS)
                it.data = seq[15:8];
            else if (p == tfsc_pkg::SEQ_LO_POS)
                it.data = seq[7:0];
            else if (p < tfsc_pkg::HEADER_LEN)
                it.data = 8'($urandom);
            else if ($urandom_range(0, 99) < err_pct)
                it.data = pattern ^ 8'($urandom_range(1, 255));
            else
                it.data = pattern;
            link_items.push_back(it);
        end
    endtask

    task automatic queue_whole(input logic [15:0] seq, input int len, input int err_pct,
                               input int tick_pct);
        queue_frame(seq, len, 0, len, err_pct, tick_pct);
    endtask

    // Mostly well-formed frames in sequence, with runts, gaps, repeats and jumps.
    task automatic random_traffic(input int item_goal, input int frame_goal);
        int base;
        int frames;
        int pick;
        int len;
        base = link_items.size();
        frames = 0;
        while (link_items.size() - base < item_goal || frames < frame_goal)
        begin
            if ($urandom_range(0, 2) == 0)
                queue_tick();
            pick = $urandom_range(0, 99);
            if (pick < 15)
                len = $urandom_range(1, tfsc_pkg::HEADER_LEN - 1);
            else if (pick < 92)
                len = $urandom_range(tfsc_pkg::HEADER_LEN, 32);
            else
                len = $urandom_range(33, 200);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                stim_seq = stim_seq + 1;
            else if (pick < 90 && pick >= 80)
                stim_seq = stim_seq + 16'($urandom_range(2, 20));
            else if (pick >= 90)
                stim_seq = 16'($urandom);
            queue_whole(stim_seq, len, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 30),
                        3 * $urandom_range(0, 1));
            frames++;
        end
    endtask

    // Sender pause: everything pushed, every report popped, block settled.
    task automatic wait_idle();
        while (link_items.size() != 0 || push || frame_reports_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input tfsc_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic chk, input logic [15:0] ivl);
        wait_idle();
        write_reg(tfsc_pkg::CFG_CHECK_PAYLOAD, {15'($urandom), chk});
        write_reg(tfsc_pkg::CFG_STATS_IVL, ivl);
        sender_gaps_on = $urandom_range(0, 3) != 0;
        receiver_gaps_on = $urandom_range(0, 3) != 0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: runts, sequence wrap, repeat, big jump, errors, mid-frame ticks
        set_config(1'b1, 16'd1);
        queue_whole(16'h1234, 1, 0, 0);
        queue_tick();
        queue_whole(16'hFFFF, tfsc_pkg::HEADER_LEN, 0, 0);
        queue_whole(16'h0000, tfsc_pkg::HEADER_LEN + 1, 0, 0);
        queue_whole(16'h0000, 24, 0, 0);
        queue_whole(16'hA55A, 30, 100, 0);
        queue_tick();
        queue_whole(16'h5AA5, tfsc_pkg::HEADER_LEN - 1, 0, 0);
        queue_whole(16'h0003, 40, 0, 20);
        queue_tick();
        queue_tick();
        queue_whole(16'h8001, 22, 10, 0);
        queue_whole(16'h80FF, 3, 0, 0);

        // interval zero: a report at every frame end; compare off
        set_config(1'b0, 16'd0);
        queue_whole(16'h8002, 25, 50, 0);
        queue_whole(16'h8003, tfsc_pkg::HEADER_LEN, 0, 0);
        queue_whole(16'h8003, 2, 0, 0);
        // payload compare switched on in the middle of a frame
        queue_frame(16'h8004, 40, 0, 30, 100, 0);
        wait_idle();
        write_reg(tfsc_pkg::CFG_CHECK_PAYLOAD, 16'h0001);
        queue_frame(16'h8004, 40, 30, 40, 100, 0);

        // interval of two seconds reached by ticks between frames
        set_config(1'b1, 16'd2);
        queue_tick();
        queue_tick();
        queue_whole(16'h7FFF, 26, 0, 0);

        stim_seq = 16'h7FFF;
        set_config(1'b1, 16'd1);
        random_traffic(80, 3);
        set_config(1'b0, 16'd2);
        random_traffic(80, 3);

        // receiver holds off while short frames keep coming: input must stall
        set_config(1'b1, 16'd1);
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        @(negedge clk);
        recv_hold = LONG_HOLD;
        for (int k = 0; k < 30; k++)
            queue_whole(16'($urandom), $urandom_range(1, 3), 0, 0);
        random_traffic(40, 2);

        set_config(1'b1, 16'd0);
        random_traffic(80, 3);
        set_config(1'b1, 16'hFFFF);
        random_traffic(80, 3);
        set_config(1'b0, 16'd1);
        random_traffic(80, 3);
        set_config(1'b1, 16'd3);
        random_traffic(80, 3);

        // closing stretch with no idling on either side
        set_config(1'b1, 16'd1);
        sender_gaps_on = 1'b0;
        receiver_gaps_on = 1'b0;
        random_traffic(80, 3);
        wait_idle();
        repeat (8) @(negedge clk);

        $display("Run covered %0d byte and %0d tick transfers, %0d frame reports", bytes_in,
                 ticks_in, reports_out);
        $display("(%0d runts, %0d flagged, %0d interval reports), %0d cycles input stalled",
                 runts_out, flagged_out, ivl_reports, full_stalls);
        if (fail_count == 0)
            $display("test_frame_sequence_checker_top verification clean");
        else
            $display("test_frame_sequence_checker_top verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/tfsc_pkg.sv
hdl/tfsc_front.sv
hdl/tfsc_queue.sv
hdl/tfsc_back.sv
hdl/test_frame_sequence_checker_top.sv
tb/tb_test_frame_sequence_checker_top.sv
